// ===== rtl/vmdd_pkg.sv =====
// package for the vector magnitude directional derivative unit
// shared state enum, request and register codes and constants, no dependencies
`default_nettype none
package vmdd_pkg;
  localparam int unsigned SizeZMax = 4096;
  localparam int unsigned DerivBits = 34;
  localparam int unsigned MagBits = 16;
  localparam int unsigned CompBits = 16;

  // request kinds on mode
  localparam logic ModeVoxel = 1'b0;
  localparam logic ModeDrain = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegSizeX = 2'd0;
  localparam logic [1:0] RegSizeY = 2'd1;
  localparam logic [1:0] RegSizeZ = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQRT,
    ST_READ,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/vector_magnitude_directional_derivative_unit.sv =====
// top level of the vector magnitude directional derivative unit
// uses vmdd_pkg; holds the magnitude and vector ring memories
//
// usage:
//  - voxel requests (mode_i = 0) arrive in raster order, x fastest. drain requests
//    (mode_i = 1) push out one pending result once the whole volume is in
//  - each voxel's magnitude goes through a bit-serial square root (one result bit
//    per cycle, 17 steps) and is written to the magnitude ring; the vector goes to
//    the delay ring
//  - a result comes out one plane plus one row after its voxel. it needs seven reads
//    of the single-port magnitude ring, one a cycle, while the vector ring read runs
//    alongside; the new voxel is stored only after that gather
//  - a voxel request is taken in idle only; the next one is taken after its square
//    root, or when it pushes out a result, after that result's gather and output
//  - a drain request gives its result at the end of its gather, then goes idle
//  - result: derivative_o, magnitude_o, last_voxel_o with out_valid_o / out_stall_i.
//    a stalled result holds and requests are still taken; a second result waits at
//    the end of its gather until the first one is taken
//  - reset clears positions, sets sizes 64/64/64 (x, y capped at MAX_X, MAX_Y);
//    ring contents are undefined; only entries written in this volume are used
//  - a write to a size register restarts the volume and drops pending results
`default_nettype none
module vector_magnitude_directional_derivative_unit
  import vmdd_pkg::*;
#(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic signed [15:0] comp_x_i,
  input  wire logic signed [15:0] comp_y_i,
  input  wire logic signed [15:0] comp_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [DerivBits-1:0] derivative_o,
  output logic [MagBits-1:0] magnitude_o,
  output logic             last_voxel_o
);
  localparam int unsigned Plane = MAX_X * MAX_Y;
  localparam int unsigned MagDepth = 3 * Plane;
  localparam int unsigned VecDepth = Plane + MAX_X;
  localparam int unsigned MagAw = $clog2(MagDepth);
  localparam int unsigned VecAw = $clog2(VecDepth);
  localparam int unsigned XW = $clog2(MAX_X + 1);
  localparam int unsigned YW = $clog2(MAX_Y + 1);
  localparam int unsigned ZW = 13;
  localparam int unsigned PW = $clog2(Plane * SizeZMax + 1);
  localparam int unsigned SqW = 2 * CompBits + 2;
  localparam int unsigned RootW = CompBits + 1;
  localparam int unsigned SqSteps = RootW;
  localparam int unsigned StW = $clog2(SqSteps + 1);

  // sizes
  logic [XW-1:0] sx_q;
  logic [YW-1:0] sy_q;
  logic [ZW-1:0] sz_q;
  logic [PW-1:0] plane_q, total_q;

  function automatic logic [ZW-1:0] clampv(logic [ZW-1:0] v, logic [ZW-1:0] hi);
    logic [ZW-1:0] r;
    r = v;
    if (v == '0) r = ZW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // memories
  logic [MagBits-1:0] mag_mem [MagDepth];
  logic [3*CompBits-1:0] vec_mem [VecDepth];
  logic mag_we, vec_we;
  logic [MagAw-1:0] mag_addr;
  logic [VecAw-1:0] vec_addr;
  logic [MagBits-1:0] mag_wd, mag_rd_q;
  logic [3*CompBits-1:0] vec_wd, vec_rd_q;

  always_ff @(posedge clk_i) begin
    if (mag_we) mag_mem[mag_addr] <= mag_wd;
    else mag_rd_q <= mag_mem[mag_addr];
  end
  always_ff @(posedge clk_i) begin
    if (vec_we) vec_mem[vec_addr] <= vec_wd;
    else vec_rd_q <= vec_mem[vec_addr];
  end

  state_e state_q, state_d;
  logic [PW-1:0] inpos_q, outpos_q;
  // ring pointers for input position (and the output vector pointer)
  logic [MagAw-1:0] in_mag_q;
  logic [VecAw-1:0] in_vec_q, out_vec_q;
  // output voxel coordinates and ring pointer, and the magnitude ring length
  logic [MagAw-1:0] out_mag_q;
  logic [XW-1:0] ox_q;
  logic [YW-1:0] oy_q;
  logic [ZW-1:0] oz_q;
  logic [MagAw-1:0] ring_q;
  logic emit_pend_q, drain_q;

  // square root
  logic [SqW-1:0] rem_q, sum_q;
  logic [RootW-1:0] root_q;
  logic [StW-1:0] step_q;
  logic [3*CompBits-1:0] vin_q;

  // gather
  logic [3:0] rd_q;
  logic [MagBits-1:0] m_q [7];
  logic signed [DerivBits-1:0] acc_q;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  logic signed [CompBits-1:0] cx, cy, cz;
  assign cx = comp_x_i[CompBits-1:0];
  assign cy = comp_y_i[CompBits-1:0];
  assign cz = comp_z_i[CompBits-1:0];

  logic [SqW-1:0] sqx, sqy, sqz;
  assign sqx = $unsigned(SqW'(cx) * SqW'(cx));
  assign sqy = $unsigned(SqW'(cy) * SqW'(cy));
  assign sqz = $unsigned(SqW'(cz) * SqW'(cz));

  // ring address helpers
  function automatic logic [MagAw-1:0] radd(logic [MagAw-1:0] a, logic [PW-1:0] d,
                                            logic [MagAw-1:0] r);
    logic [MagAw:0] s;
    s = {1'b0, a} + (MagAw+1)'(d);
    if (s >= {1'b0, r}) s = s - {1'b0, r};
    return s[MagAw-1:0];
  endfunction
  function automatic logic [MagAw-1:0] rsub(logic [MagAw-1:0] a, logic [PW-1:0] d,
                                            logic [MagAw-1:0] r);
    logic [MagAw:0] s;
    s = {1'b0, a} + {1'b0, r} - (MagAw+1)'(d);
    if (s >= {1'b0, r}) s = s - {1'b0, r};
    return s[MagAw-1:0];
  endfunction

  // trial for the square root: (root << 2 | 1), set against the shifted remainder
  logic [SqW-1:0] trial;
  logic [SqW-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[SqW-3:0], sum_q[SqW-1:SqW-2]};
    trial = {(SqW-RootW-2)'(0), root_q, 2'b01};
  end

  // read address of each gather step: 0 self, then xl xr yl yr zl zr
  logic [MagAw-1:0] gaddr;
  logic [PW-1:0] psx;
  assign psx = PW'(sx_q);
  always_comb begin
    unique case (rd_q)
      4'd1: gaddr = rsub(out_mag_q, PW'(1), ring_q);
      4'd2: gaddr = radd(out_mag_q, PW'(1), ring_q);
      4'd3: gaddr = rsub(out_mag_q, psx, ring_q);
      4'd4: gaddr = radd(out_mag_q, psx, ring_q);
      4'd5: gaddr = rsub(out_mag_q, plane_q, ring_q);
      4'd6: gaddr = radd(out_mag_q, plane_q, ring_q);
      default: gaddr = out_mag_q;
    endcase
  end

  // neighbor use masks
  logic use_xl, use_xr, use_yl, use_yr, use_zl, use_zr;
  assign use_xl = ox_q != '0;
  assign use_xr = (ox_q + XW'(1)) != sx_q;
  assign use_yl = oy_q != '0;
  assign use_yr = (oy_q + YW'(1)) != sy_q;
  assign use_zl = oz_q != '0;
  assign use_zr = (oz_q + ZW'(1)) != sz_q;

  always_comb begin
    state_d = state_q;
    mag_we = 1'b0;
    vec_we = 1'b0;
    mag_addr = gaddr;
    vec_addr = out_vec_q;
    mag_wd = MagBits'(root_q);
    vec_wd = vin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == ModeVoxel && inpos_q < total_q) state_d = ST_SQRT;
          else if (mode_i == ModeDrain && inpos_q == total_q && outpos_q < total_q)
            state_d = ST_READ;
        end
      end
      ST_SQRT: begin
        if (step_q == StW'(SqSteps)) begin
          if (emit_pend_q) begin
            // oldest result goes first, the voxel is stored after its gather
            state_d = ST_READ;
          end else begin
            mag_we = 1'b1;
            vec_we = 1'b1;
            mag_addr = in_mag_q;
            vec_addr = in_vec_q;
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        // a result still waiting holds the gather at its last step
        if (rd_q == 4'd8 && !out_valid_o) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!drain_q) begin
          mag_we = 1'b1;
          vec_we = 1'b1;
          mag_addr = in_mag_q;
          vec_addr = in_vec_q;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // products per axis, one axis at a time through a shared multiplier
  logic signed [MagBits+1:0] diff;
  logic signed [CompBits-1:0] vcomp;
  logic [1:0] axis;
  always_comb begin
    axis = 2'd0;
    diff = '0;
    if (rd_q == 4'd4) begin
      axis = 2'd0;
      diff = $signed({2'b0, use_xr ? m_q[2] : m_q[0]}) - $signed({2'b0, use_xl ? m_q[1] : m_q[0]});
    end else if (rd_q == 4'd6) begin
      axis = 2'd1;
      diff = $signed({2'b0, use_yr ? m_q[4] : m_q[0]}) - $signed({2'b0, use_yl ? m_q[3] : m_q[0]});
    end else if (rd_q == 4'd8) begin
      axis = 2'd2;
      diff = $signed({2'b0, use_zr ? m_q[6] : m_q[0]}) - $signed({2'b0, use_zl ? m_q[5] : m_q[0]});
    end
    unique case (axis)
      2'd0: vcomp = vec_rd_q[CompBits-1:0];
      2'd1: vcomp = vec_rd_q[2*CompBits-1:CompBits];
      default: vcomp = vec_rd_q[3*CompBits-1:2*CompBits];
    endcase
  end
  logic signed [DerivBits-1:0] prod;
  assign prod = DerivBits'(diff) * DerivBits'(vcomp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sx_q <= XW'(MAX_X < 64 ? MAX_X : 64);
      sy_q <= YW'(MAX_Y < 64 ? MAX_Y : 64);
      sz_q <= ZW'(64);
      plane_q <= PW'((MAX_X < 64 ? MAX_X : 64) * (MAX_Y < 64 ? MAX_Y : 64));
      total_q <= PW'((MAX_X < 64 ? MAX_X : 64) * (MAX_Y < 64 ? MAX_Y : 64) * 64);
      ring_q <= MagAw'(3 * (MAX_X < 64 ? MAX_X : 64) * (MAX_Y < 64 ? MAX_Y : 64));
      inpos_q <= '0;
      outpos_q <= '0;
      in_mag_q <= '0;
      in_vec_q <= '0;
      out_mag_q <= '0;
      out_vec_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
      out_valid_o <= 1'b0;
      emit_pend_q <= 1'b0;
      drain_q <= 1'b0;
      step_q <= '0;
      rd_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegSizeX: sx_q <= XW'(clampv(ZW'(cfg_data_i[6:0]), ZW'(MAX_X)));
          RegSizeY: sy_q <= YW'(clampv(ZW'(cfg_data_i[6:0]), ZW'(MAX_Y)));
          RegSizeZ: sz_q <= clampv(cfg_data_i, ZW'(SizeZMax));
          default: ;
        endcase
        if (cfg_index_i == RegSizeX || cfg_index_i == RegSizeY ||
            cfg_index_i == RegSizeZ) begin
          inpos_q <= '0; outpos_q <= '0; in_mag_q <= '0; in_vec_q <= '0;
          out_mag_q <= '0; out_vec_q <= '0; ox_q <= '0; oy_q <= '0; oz_q <= '0;
        end
      end else begin
        plane_q <= PW'(sx_q) * PW'(sy_q);
        total_q <= PW'(PW'(sx_q) * PW'(sy_q) * PW'(sz_q));
        ring_q <= MagAw'(3 * PW'(sx_q) * PW'(sy_q));
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && state_d == ST_SQRT) begin
            sum_q <= sqx + sqy + sqz;
            rem_q <= '0;
            root_q <= '0;
            step_q <= '0;
            vin_q <= {cz, cy, cx};
            emit_pend_q <= (inpos_q - outpos_q) >= (plane_q + PW'(sx_q));
            drain_q <= 1'b0;
          end else if (in_acc && state_d == ST_READ) begin
            drain_q <= 1'b1;
            rd_q <= '0;
          end
        end
        ST_SQRT: begin
          if (step_q != StW'(SqSteps)) begin
            step_q <= step_q + StW'(1);
            sum_q <= {sum_q[SqW-3:0], 2'b00};
            if (rem_sh >= trial) begin
              rem_q <= rem_sh - trial;
              root_q <= {root_q[RootW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              root_q <= {root_q[RootW-2:0], 1'b0};
            end
          end else if (emit_pend_q) begin
            rd_q <= '0;
          end else begin
            inpos_q <= inpos_q + PW'(1);
            in_mag_q <= radd(in_mag_q, PW'(1), ring_q);
            in_vec_q <= (in_vec_q + VecAw'(1) == VecAw'(plane_q + PW'(sx_q))) ?
                        '0 : in_vec_q + VecAw'(1);
          end
        end
        ST_READ: begin
          if (rd_q != 4'd8) begin
            rd_q <= rd_q + 4'd1;
            if (rd_q >= 4'd1 && rd_q <= 4'd7) m_q[3'(rd_q - 4'd1)] <= mag_rd_q;
            if (rd_q == 4'd1) acc_q <= '0;
            if (rd_q == 4'd4 || rd_q == 4'd6) acc_q <= acc_q + prod;
          end else if (!out_valid_o) begin
            derivative_o <= acc_q + prod;
            magnitude_o <= m_q[0];
            last_voxel_o <= (outpos_q + PW'(1)) == total_q;
            out_valid_o <= 1'b1;
            outpos_q <= outpos_q + PW'(1);
            out_mag_q <= radd(out_mag_q, PW'(1), ring_q);
            out_vec_q <= (out_vec_q + VecAw'(1) == VecAw'(plane_q + PW'(sx_q))) ?
                         '0 : out_vec_q + VecAw'(1);
            if (ox_q + XW'(1) == sx_q) begin
              ox_q <= '0;
              if (oy_q + YW'(1) == sy_q) begin
                oy_q <= '0;
                oz_q <= oz_q + ZW'(1);
              end else oy_q <= oy_q + YW'(1);
            end else ox_q <= ox_q + XW'(1);
            if (drain_q && (outpos_q + PW'(1)) == total_q) begin
              inpos_q <= '0; outpos_q <= '0; in_mag_q <= '0; in_vec_q <= '0;
              out_mag_q <= '0; out_vec_q <= '0; ox_q <= '0; oy_q <= '0; oz_q <= '0;
            end
          end
        end
        ST_OUT: begin
          // voxel stored once its older result is out
          if (!drain_q) begin
            inpos_q <= inpos_q + PW'(1);
            in_mag_q <= radd(in_mag_q, PW'(1), ring_q);
            in_vec_q <= (in_vec_q + VecAw'(1) == VecAw'(plane_q + PW'(sx_q))) ?
                        '0 : in_vec_q + VecAw'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // self magnitude at rd 1 is in m_q[0]; the vector read runs alongside step 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> in_stall_o)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outpos_q <= inpos_q)
    else $error("output ahead of input");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && rd_q == 4'd8 && out_valid_o) |=> (state_q == ST_READ))
    else $error("gather finished over a waiting result");
endmodule
`default_nettype wire
